### src/fk7_pkg.sv
package fk7_pkg;

	// Internal fixed-point format: signed Q.24 held in 28 bits.
	localparam int DATA_WIDTH_DEF = 24;
	localparam int IQ             = 24;
	localparam int IW             = 28;
	localparam int PW             = 58;
	localparam int NJ             = 7;
	localparam int NITER          = 24;

	typedef logic signed [IW-1:0] q_t;

	localparam q_t PI_Q      = 28'sd52707179;
	localparam q_t HALF_PI_Q = 28'sd26353589;
	localparam q_t TWO_PI_Q  = 28'sd105414357;
	localparam q_t GAIN_Q    = 28'sd10188014;
	localparam q_t ONE_Q     = 28'sd16777216;

	localparam logic signed [PW-1:0] RND_HALF = 58'sd8388608;

	localparam logic [1:0] ROW_LAST   = 2'd2;
	localparam logic [2:0] FRAME_LAST = 3'd7;
	localparam logic [2:0] JOINT_LAST = 3'd6;

	typedef enum logic [1:0] {
		TW_NONE,
		TW_POS,
		TW_NEG
	} twist_t;

	localparam q_t LINK_TX [NJ] = '{28'sd0, 28'sd0, 28'sd0, 28'sd1384120,
		-28'sd1384120, 28'sd0, 28'sd1476395};
	localparam q_t LINK_TY [NJ] = '{28'sd0, 28'sd0, -28'sd5301600, 28'sd0,
		28'sd6442451, 28'sd0, 28'sd0};
	localparam q_t LINK_TZ [NJ] = '{28'sd5586813, 28'sd0, 28'sd0, 28'sd0,
		28'sd0, 28'sd0, 28'sd0};
	localparam twist_t LINK_TWIST [NJ] = '{TW_NONE, TW_NEG, TW_POS, TW_POS,
		TW_NEG, TW_POS, TW_POS};

	// Angle step of one CORDIC iteration, atan(2^-i) in Q.24.
	function automatic q_t cordic_step(input int i);
		case (i)
			0: cordic_step = 28'sd13176795;
			1: cordic_step = 28'sd7778716;
			2: cordic_step = 28'sd4110060;
			3: cordic_step = 28'sd2086331;
			4: cordic_step = 28'sd1047214;
			5: cordic_step = 28'sd524117;
			6: cordic_step = 28'sd262123;
			7: cordic_step = 28'sd131069;
			default: cordic_step = q_t'(28'sd1 <<< (IQ - i));
		endcase
	endfunction

	typedef struct packed {
		logic       valid;
		logic       bank;
		logic [2:0] joint;
		logic       neg;
		q_t         x;
		q_t         y;
		q_t         z;
	} cor_tok_t;

	typedef struct packed {
		logic            valid;
		logic            bank;
		logic [1:0]      row;
		q_t [3:0]        m;
		q_t [NJ-1:0]     cosv;
		q_t [NJ-1:0]     sinv;
	} row_tok_t;

endpackage

### src/fk7_cordic_cell.sv
module fk7_cordic_cell
	import fk7_pkg::*;
#(
	parameter int ITER = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cor_tok_t din,
	output cor_tok_t dout
);

	localparam q_t STEP = cordic_step(ITER);

	cor_tok_t nxt;
	cor_tok_t tok_q;
	q_t       dx;
	q_t       dy;

	always_comb begin
		nxt = din;
		dx  = $signed(din.y) >>> ITER;
		dy  = $signed(din.x) >>> ITER;
		if (!din.z[IW-1]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - STEP;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
		end
	end

	assign dout = tok_q;

endmodule

### src/fk7_link_cell.sv
module fk7_link_cell
	import fk7_pkg::*;
#(
	parameter int LINK = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  row_tok_t   din,
	output row_tok_t   dout,
	input  logic       rd_bank,
	input  logic [1:0] rd_row,
	output q_t [3:0]   rd_m
);

	localparam q_t     TX = LINK_TX[LINK];
	localparam q_t     TY = LINK_TY[LINK];
	localparam q_t     TZ = LINK_TZ[LINK];
	localparam twist_t TW = LINK_TWIST[LINK];

	row_tok_t                tok_s1;
	row_tok_t                tok_s2;
	row_tok_t                tok_s3;
	row_tok_t                nxt1;
	row_tok_t                nxt3;
	logic signed [PW-1:0]    tsum;
	logic signed [PW-1:0]    sum0;
	logic signed [PW-1:0]    sum1;
	logic signed [2*IW-1:0]  pcc0_s2;
	logic signed [2*IW-1:0]  psc1_s2;
	logic signed [2*IW-1:0]  pcc1_s2;
	logic signed [2*IW-1:0]  psc0_s2;
	q_t                      cv;
	q_t                      sv;
	q_t [3:0]                ent_q [2][3];

	// Offset first, then the fixed twist about x.
	always_comb begin
		nxt1 = din;
		tsum = $signed(din.m[0]) * TX + $signed(din.m[1]) * TY + $signed(din.m[2]) * TZ;
		nxt1.m[3] = din.m[3] + IW'((tsum + RND_HALF) >>> IQ);
		case (TW)
			TW_POS: begin
				nxt1.m[1] = din.m[2];
				nxt1.m[2] = -din.m[1];
			end
			TW_NEG: begin
				nxt1.m[1] = -din.m[2];
				nxt1.m[2] = din.m[1];
			end
			default: begin
				nxt1.m[1] = din.m[1];
				nxt1.m[2] = din.m[2];
			end
		endcase
	end

	assign cv = tok_s1.cosv[LINK];
	assign sv = tok_s1.sinv[LINK];

	always_comb begin
		nxt3 = tok_s2;
		sum0 = PW'(pcc0_s2) + PW'(psc1_s2) + RND_HALF;
		sum1 = PW'(pcc1_s2) - PW'(psc0_s2) + RND_HALF;
		nxt3.m[0] = IW'(sum0 >>> IQ);
		nxt3.m[1] = IW'(sum1 >>> IQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else begin
			tok_s1 <= nxt1;
			tok_s2 <= tok_s1;
			tok_s3 <= nxt3;
		end
	end

	always_ff @(posedge clk) begin
		pcc0_s2 <= cv * $signed(tok_s1.m[0]);
		psc1_s2 <= sv * $signed(tok_s1.m[1]);
		pcc1_s2 <= cv * $signed(tok_s1.m[1]);
		psc0_s2 <= sv * $signed(tok_s1.m[0]);
		if (tok_s3.valid) begin
			ent_q[tok_s3.bank][tok_s3.row] <= tok_s3.m;
		end
	end

	assign dout = tok_s3;
	assign rd_m = ent_q[rd_bank][rd_row];

endmodule

### src/forward_kinematics_7dof_arm_top.sv
// Forward kinematics of a fixed seven-joint serial arm.
//
// Input channel (s_axis_*): one transfer carries all seven joint angles,
// signed Q3.(DATA_WIDTH-4) radians. Output channel (m_axis_*): each input
// yields 24 transfers, frames 0 to 7 with rows 0 to 2 each, frame 0 row 0
// first. Each output transfer carries one row of the 3x4 frame matrix;
// tlast marks row 2 of frame 7.
//
// The seven angles enter a 24-cell CORDIC chain one per cycle, so the
// input takes no new transfer until all seven are fed. The three rows then
// walk a chain of seven link cells, three pipeline stages each; every cell
// keeps the rows of its frame in two result banks. A bank frees only when
// its last row is loaded into the output register, so the block accepts a
// new item while an earlier one is still in flight, up to two items in all.
//
// Reset clears all valid flags and bank ownership; no clearing pass runs.
// When the receiver stalls, the output register holds its row, the banks
// fill, and the input stops accepting once both banks are taken.
module forward_kinematics_7dof_arm_top
	import fk7_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// joint_angle_1 .. joint_angle_7, DATA_WIDTH bits each, from bit 0 up
	input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// frame_index[2:0], row_index[1:0], rot_col_x, rot_col_y, rot_col_z,
	// position, from bit 0 up
	output logic [((5+4*DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
	output logic                                         m_axis_tlast
);

	localparam int FRAC  = DATA_WIDTH - 4;
	localparam int OUT_W = ((5 + 4*DATA_WIDTH + 7) / 8) * 8;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	// Intake and angle feed.
	logic                          acc;
	logic                          feeding_q;
	logic [2:0]                    feed_j_q;
	logic                          feed_bank_q;
	logic                          wr_bank_q;
	logic [1:0]                    free_q;
	logic signed [DATA_WIDTH-1:0]  ang_q [NJ];
	logic signed [DATA_WIDTH-1:0]  ang_cur;
	logic signed [63:0]            ang_wide;
	q_t                            a0;
	q_t                            a1;
	logic                          neg;

	assign s_axis_tready = !feeding_q && (free_q != 2'd0);
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feeding_q   <= 1'b0;
			feed_j_q    <= '0;
			feed_bank_q <= 1'b0;
			wr_bank_q   <= 1'b0;
		end else if (acc) begin
			feeding_q   <= 1'b1;
			feed_j_q    <= '0;
			feed_bank_q <= wr_bank_q;
			wr_bank_q   <= !wr_bank_q;
		end else if (feeding_q) begin
			if (feed_j_q == JOINT_LAST) begin
				feeding_q <= 1'b0;
			end
			feed_j_q <= feed_j_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < NJ; k++) begin
				ang_q[k] <= s_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH];
			end
		end
	end

	assign ang_cur = ang_q[feed_j_q];

	// Angle to Q.24, rounding half up when the input carries more fraction bits.
	generate
		if (FRAC <= IQ) begin : g_ang_up
			assign ang_wide = 64'(ang_cur) <<< (IQ - FRAC);
		end else begin : g_ang_dn
			assign ang_wide = (64'(ang_cur) + (64'sd1 <<< (FRAC - IQ - 1))) >>> (FRAC - IQ);
		end
	endgenerate

	// Fold the angle into [-pi/2, pi/2]; a fold by pi negates both results.
	always_comb begin
		a0 = IW'(ang_wide);
		if (a0 > PI_Q) begin
			a0 = a0 - TWO_PI_Q;
		end else if (a0 < -PI_Q) begin
			a0 = a0 + TWO_PI_Q;
		end
		neg = 1'b0;
		a1  = a0;
		if (a0 > HALF_PI_Q) begin
			a1  = a0 - PI_Q;
			neg = 1'b1;
		end else if (a0 < -HALF_PI_Q) begin
			a1  = a0 + PI_Q;
			neg = 1'b1;
		end
	end

	// CORDIC chain.
	cor_tok_t cor_c [NITER+1];
	cor_tok_t prep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q <= '0;
		end else begin
			prep_q.valid <= feeding_q;
			prep_q.bank  <= feed_bank_q;
			prep_q.joint <= feed_j_q;
			prep_q.neg   <= neg;
			prep_q.x     <= GAIN_Q;
			prep_q.y     <= '0;
			prep_q.z     <= a1;
		end
	end

	assign cor_c[0] = prep_q;

	generate
		for (genvar i = 0; i < NITER; i++) begin : g_cor
			fk7_cordic_cell #(.ITER(i)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.din    (cor_c[i]),
				.dout   (cor_c[i+1])
			);
		end
	endgenerate

	// Collect the seven cosine/sine pairs, then launch three row transfers.
	cor_tok_t     cor_out;
	q_t           cos_new;
	q_t           sin_new;
	q_t           col_cos_q [NJ];
	q_t           col_sin_q [NJ];
	q_t [NJ-1:0]  lau_cos_q;
	q_t [NJ-1:0]  lau_sin_q;
	logic         lau_act_q;
	logic [1:0]   lau_row_q;
	logic         lau_bank_q;
	row_tok_t     lau_tok;

	assign cor_out = cor_c[NITER];
	assign cos_new = cor_out.neg ? -cor_out.x : cor_out.x;
	assign sin_new = cor_out.neg ? -cor_out.y : cor_out.y;

	always_ff @(posedge clk) begin
		if (cor_out.valid) begin
			col_cos_q[cor_out.joint] <= cos_new;
			col_sin_q[cor_out.joint] <= sin_new;
			if (cor_out.joint == JOINT_LAST) begin
				for (int k = 0; k < NJ - 1; k++) begin
					lau_cos_q[k] <= col_cos_q[k];
					lau_sin_q[k] <= col_sin_q[k];
				end
				lau_cos_q[NJ-1] <= cos_new;
				lau_sin_q[NJ-1] <= sin_new;
				lau_bank_q      <= cor_out.bank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lau_act_q <= 1'b0;
			lau_row_q <= '0;
		end else if (cor_out.valid && cor_out.joint == JOINT_LAST) begin
			lau_act_q <= 1'b1;
			lau_row_q <= '0;
		end else if (lau_act_q) begin
			if (lau_row_q == ROW_LAST) begin
				lau_act_q <= 1'b0;
			end
			lau_row_q <= lau_row_q + 2'd1;
		end
	end

	always_comb begin
		lau_tok       = '0;
		lau_tok.valid = lau_act_q;
		lau_tok.bank  = lau_bank_q;
		lau_tok.row   = lau_row_q;
		lau_tok.cosv  = lau_cos_q;
		lau_tok.sinv  = lau_sin_q;
		for (int c = 0; c < 3; c++) begin
			lau_tok.m[c] = (2'(c) == lau_row_q) ? ONE_Q : '0;
		end
	end

	// Chain of link cells; cell k produces frame k+1.
	row_tok_t    lnk_c [NJ+1];
	q_t [3:0]    cell_rd [NJ];
	logic        rd_bank_q;
	logic [2:0]  frame_q;
	logic [1:0]  row_q;

	assign lnk_c[0] = lau_tok;

	generate
		for (genvar k = 0; k < NJ; k++) begin : g_link
			fk7_link_cell #(.LINK(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.din     (lnk_c[k]),
				.dout    (lnk_c[k+1]),
				.rd_bank (rd_bank_q),
				.rd_row  (row_q),
				.rd_m    (cell_rd[k])
			);
		end
	endgenerate

	// Bank ownership and readout.
	logic [1:0]                    full_q;
	logic [1:0]                    full_set;
	logic [1:0]                    full_clr;
	logic                          ld;
	logic                          rel;
	q_t [3:0]                      src_m;
	logic signed [63:0]            cv_r [4];
	logic signed [DATA_WIDTH-1:0]  cv_o [4];
	logic                          ov_q;
	logic [2:0]                    o_frame_q;
	logic [1:0]                    o_row_q;
	logic                          o_last_q;
	logic signed [DATA_WIDTH-1:0]  o_val_q [4];

	assign ld  = full_q[rd_bank_q] && (!ov_q || m_axis_tready);
	assign rel = ld && (frame_q == FRAME_LAST) && (row_q == ROW_LAST);

	// A bank becomes full when its row 2 leaves the last cell and empties
	// when its final row is loaded into the output register.
	assign full_set = (lnk_c[NJ].valid && lnk_c[NJ].row == ROW_LAST) ?
		(2'b01 << lnk_c[NJ].bank) : 2'b00;
	assign full_clr = rel ? (2'b01 << rd_bank_q) : 2'b00;

	always_comb begin
		if (frame_q == 3'd0) begin
			for (int c = 0; c < 4; c++) begin
				src_m[c] = (2'(c) == row_q) ? ONE_Q : '0;
			end
		end else begin
			src_m = cell_rd[3'(frame_q - 3'd1)];
		end
	end

	generate
		for (genvar c = 0; c < 4; c++) begin : g_conv
			if (FRAC >= IQ) begin : g_up
				assign cv_r[c] = 64'($signed(src_m[c])) <<< (FRAC - IQ);
			end else begin : g_dn
				assign cv_r[c] = (64'($signed(src_m[c])) + (64'sd1 <<< (IQ - FRAC - 1)))
					>>> (IQ - FRAC);
			end
			assign cv_o[c] = (cv_r[c] > SAT_HI) ? DATA_WIDTH'(SAT_HI) :
				(cv_r[c] < SAT_LO) ? DATA_WIDTH'(SAT_LO) : DATA_WIDTH'(cv_r[c]);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= '0;
			free_q    <= 2'd2;
			rd_bank_q <= 1'b0;
			frame_q   <= '0;
			row_q     <= '0;
			ov_q      <= 1'b0;
		end else begin
			full_q <= (full_q | full_set) & ~full_clr;
			if (rel) begin
				rd_bank_q <= !rd_bank_q;
			end
			case ({acc, rel})
				2'b10:   free_q <= free_q - 2'd1;
				2'b01:   free_q <= free_q + 2'd1;
				default: free_q <= free_q;
			endcase
			if (ld) begin
				ov_q <= 1'b1;
				if (row_q == ROW_LAST) begin
					row_q   <= '0;
					frame_q <= frame_q + 3'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			o_frame_q <= frame_q;
			o_row_q   <= row_q;
			o_last_q  <= (frame_q == FRAME_LAST) && (row_q == ROW_LAST);
			for (int c = 0; c < 4; c++) begin
				o_val_q[c] <= cv_o[c];
			end
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = OUT_W'({o_val_q[3], o_val_q[2], o_val_q[1], o_val_q[0],
		o_row_q, o_frame_q});

endmodule

### src/fk7_checker.sv
module fk7_checker
	import fk7_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic [((7*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((5+4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic                                m_axis_tlast
);

	localparam int ONE_OUT = 1 << (DATA_WIDTH - 4);

	// The end-of-item flag sits on row 2 of frame 7 and nowhere else.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast ==
			(m_axis_tdata[2:0] == 3'd7 && m_axis_tdata[4:3] == 2'd2)))
		else $error("tlast does not match frame 7 row 2");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:3] != 2'd3)
		else $error("row index out of range");

	// Row 0 of the base frame has a one in its first column and no translation.
	a_base_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2:0] == 3'd0 && m_axis_tdata[4:3] == 2'd0) |->
		(m_axis_tdata[5 +: DATA_WIDTH] == DATA_WIDTH'(ONE_OUT)
			&& m_axis_tdata[5+3*DATA_WIDTH +: DATA_WIDTH] == '0))
		else $error("base frame row 0 is not identity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output transfer changed");

endmodule

bind forward_kinematics_7dof_arm_top fk7_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fk7_checker (.*);
